// ===== design/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared pixel and result types, fixed-point constants and stage structs.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CHAN_W   = 8;
	localparam int HUE_W    = 15;
	localparam int SAT_W    = 17;
	// quotient bits produced by each divider; saturation needs 17
	localparam int QUOT_W   = 17;
	// hue numerator: 3840 * t with t up to 6*255
	localparam int NUM_W    = 23;
	localparam int DIVD_W   = QUOT_W + CHAN_W;
	localparam int HUE_TURN = 23040;
	localparam int SAT_ONE  = 65536;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	// front stage result, feeds both dividers
	typedef struct packed {
		logic [NUM_W-1:0]  num;
		logic [CHAN_W-1:0] delta;
		logic [CHAN_W-1:0] max;
		logic              grey;
		logic              black;
	} front_t;

	// sideband that rides along the hue divider
	typedef struct packed {
		logic              grey;
		logic              black;
		logic [CHAN_W-1:0] max;
	} side_t;

endpackage

// ===== design/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and delta, forms the hue numerator in 1/64 degree units.
// ----------------------------------------------------------------------------
module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_vld,
	input  pixel_t pix,
	output logic   vld_s1,
	output front_t front_s1
);

	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic [CHAN_W-1:0] delta;
	logic [11:0]       d2;
	logic [11:0]       d4;
	logic [11:0]       d6;
	logic [11:0]       t;
	logic [10:0]       t11;
	logic [NUM_W-1:0]  num;

	always_comb begin
		mx = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		mn = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		delta = mx - mn;
	end

	// sextant offset in units of delta*60 degrees; sum is never negative
	always_comb begin
		d2 = {3'b000, delta, 1'b0};
		d4 = {2'b00, delta, 2'b00};
		d6 = d2 + d4;
		if (mx == pix.red) begin
			t = {4'h0, pix.green} - {4'h0, pix.blue};
			if (pix.green < pix.blue) t = t + d6;
		end else if (mx == pix.green) begin
			t = d2 + {4'h0, pix.blue} - {4'h0, pix.red};
		end else begin
			t = d4 + {4'h0, pix.red} - {4'h0, pix.green};
		end
		t11 = t[10:0];
		// times 3840 = 4096 - 256
		num = {t11, 12'h000} - {4'h0, t11, 8'h00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		front_s1.num   <= num;
		front_s1.delta <= delta;
		front_s1.max   <= mx;
		front_s1.grey  <= (delta == '0);
		front_s1.black <= (mx == '0);
	end

endmodule

// ===== design/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rgbhsv_div
	import rgbhsv_pkg::*;
#(
	parameter int QW  = QUOT_W,
	parameter int DVW = CHAN_W,
	parameter int TW  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	// dividend must be below divisor * 2**QW
	input  logic [QW+DVW-1:0] dividend,
	input  logic [DVW-1:0]   divisor,
	input  logic [TW-1:0]    in_tag,
	output logic             out_vld,
	output logic [QW-1:0]    quotient,
	output logic [TW-1:0]    out_tag
);

	// stage k holds the partial remainder and the dividend bits still to
	// shift in, with quotient bits filling from the bottom
	logic           vld_s [1:QW];
	logic [DVW-1:0] rem_s [1:QW];
	logic [QW-1:0]  rq_s  [1:QW];
	logic [DVW-1:0] dvs_s [1:QW];
	logic [TW-1:0]  tag_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic           src_vld;
		logic [DVW-1:0] src_rem;
		logic [QW-1:0]  src_rq;
		logic [DVW-1:0] src_dvs;
		logic [TW-1:0]  src_tag;
		logic [DVW:0]   trial;
		logic [DVW:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign src_vld = in_vld;
			assign src_rem = dividend[QW+DVW-1:QW];
			assign src_rq  = dividend[QW-1:0];
			assign src_dvs = divisor;
			assign src_tag = in_tag;
		end else begin : g_next
			assign src_vld = vld_s[k];
			assign src_rem = rem_s[k];
			assign src_rq  = rq_s[k];
			assign src_dvs = dvs_s[k];
			assign src_tag = tag_s[k];
		end

		assign trial = {src_rem, src_rq[QW-1]};
		assign diff  = trial - {1'b0, src_dvs};
		assign ge    = (trial >= {1'b0, src_dvs});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			rq_s[k+1]  <= {src_rq[QW-2:0], ge};
			dvs_s[k+1] <= src_dvs;
			tag_s[k+1] <= src_tag;
		end
	end

	assign out_vld  = vld_s[QW];
	assign quotient = rq_s[QW];
	assign out_tag  = tag_s[QW];

endmodule

// ===== design/rgb_to_hsv_pixel_top.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per clock to hue, saturation and brightness.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel and raise start for one cycle per request. busy is tied low:
//   a request is taken on every cycle that start is high, back to back.
//   Each request produces one result on hsv, marked by done for exactly one
//   cycle; the receiver must take it then, there is no back-pressure.
//   Path: 1 + QUOT_W = 18 register stages, the front stage and then QUOT_W
//   divider stages; done is the valid bit of the last divider stage.
//   Throughput: one pixel per clock, sustained.
//   The pipeline is one front stage (max/min/delta and the hue numerator)
//   followed by two parallel dividers, one quotient bit per stage:
//     hue        = 3840 * t / delta   (t = sextant offset + channel diff)
//     saturation = delta * 65536 / max
//   A grey pixel forces hue to 0, a black pixel forces saturation to 0.
//   Reset (arst_n low) clears every valid bit at once; requests in flight
//   are dropped and no result appears for them.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
	import rgbhsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output hsv_t   hsv
);

	localparam int SIDE_W = $bits(side_t);

	logic              accept;
	logic              vld_s1;
	front_t            front_s1;
	side_t             side_in;
	side_t             side_out;
	logic              hue_vld;
	logic              sat_vld;
	logic [QUOT_W-1:0] hue_q;
	logic [QUOT_W-1:0] sat_q;
	logic [SIDE_W-1:0] side_bits;
	logic              sat_black;

	// every stage advances each cycle, so the block never holds off a request
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	rgbhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.pix      (pixel),
		.vld_s1   (vld_s1),
		.front_s1 (front_s1)
	);

	assign side_in.grey  = front_s1.grey;
	assign side_in.black = front_s1.black;
	assign side_in.max   = front_s1.max;

	// hue: numerator < 23040 * delta, so the quotient fits well below 2**17
	rgbhsv_div #(
		.QW  (QUOT_W),
		.DVW (CHAN_W),
		.TW  (SIDE_W)
	) u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.dividend ({{(DIVD_W-NUM_W){1'b0}}, front_s1.num}),
		.divisor  (front_s1.delta),
		.in_tag   (side_in),
		.out_vld  (hue_vld),
		.quotient (hue_q),
		.out_tag  (side_bits)
	);

	// saturation: delta <= max, so the quotient is at most 65536
	rgbhsv_div #(
		.QW  (QUOT_W),
		.DVW (CHAN_W),
		.TW  (1)
	) u_sat_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.dividend ({1'b0, front_s1.delta, {(DIVD_W-CHAN_W-1){1'b0}}}),
		.divisor  (front_s1.max),
		.in_tag   (front_s1.black),
		.out_vld  (sat_vld),
		.quotient (sat_q),
		.out_tag  (sat_black)
	);

	assign side_out = side_t'(side_bits);

	// drop the quotient for the special cases: grey has no hue, black no
	// saturation (the divider saw a zero divisor there)
	assign done           = hue_vld;
	assign hsv.hue        = side_out.grey ? '0 : hue_q[HUE_W-1:0];
	assign hsv.saturation = sat_black ? '0 : sat_q[SAT_W-1:0];
	assign hsv.brightness = side_out.max;

	// both dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		hue_vld == sat_vld)
		else $error("hue and saturation dividers out of step");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hsv.hue < HUE_TURN))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hsv.saturation <= SAT_ONE))
		else $error("saturation out of range");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (hsv.brightness == '0)) |-> (hsv.saturation == '0))
		else $error("black pixel with nonzero saturation");

	a_tag_agree: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sat_black == side_out.black))
		else $error("divider sideband mismatch");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter testbench
// Sends 8-bit RGB requests through the converter and checks hue, saturation
// and brightness of every result against an integer predictor or a typed expectation. Directed corner
// pixels come first, then random pixels under several sender idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsv_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	// register stages through the converter; the settle time adds slack
	localparam int PIPE_LATENCY = 18;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam int RANDOM_ITEMS = 1425;
	// one sixty-degree sextant expressed in 1/64 degree units
	localparam int HUE_SEXTANT  = HUE_TURN / 6;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsv_t   hsv;

	// sideband that travels with each request from the driver to the checker
	logic row_fixed;
	hsv_t row_want;

	typedef struct {
		pixel_t px;
		bit     fixed;
		hsv_t   want;
	} corner_row_t;

	corner_row_t corner_rows[$];
	hsv_t        hsv_pending[$];
	hsv_t        hsv_head;
	int          idle_pct;
	int          n_requests;
	int          n_results;
	int          n_errors;

	rgb_to_hsv_pixel_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.hsv    (hsv)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop in case a request is never taken or a result never shows up.
	initial begin
		#RUN_LIMIT_NS;
		$display("%0t: run limit reached, %0d results still pending", $time,
			hsv_pending.size());
		$display("FAIL");
		$finish;
	end

	// Integer HSV conversion: max/min/delta, then the sextant formula picked by
	// the channel holding the maximum (red before green before blue on ties).
	function automatic hsv_t convert_pixel(pixel_t p);
		int   r, g, b, mx, mn, dl, num;
		hsv_t h;
		r  = p.red;
		g  = p.green;
		b  = p.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		if (dl == 0) begin
			num = 0;
		end else if (mx == r) begin
			num = HUE_SEXTANT * (g - b);
			// wrap a negative angle into the upper end of the circle
			if (num < 0) num += HUE_TURN * dl;
		end else if (mx == g) begin
			num = 2 * HUE_SEXTANT * dl + HUE_SEXTANT * (b - r);
		end else begin
			num = 4 * HUE_SEXTANT * dl + HUE_SEXTANT * (r - g);
		end
		h.hue        = (dl == 0) ? '0 : HUE_W'(num / dl);
		h.saturation = (mx == 0) ? '0 : SAT_W'((dl * SAT_ONE) / mx);
		h.brightness = CHAN_W'(mx);
		return h;
	endfunction

	function automatic hsv_t make_hsv(int hue_v, int sat_v, int val_v);
		hsv_t h;
		h.hue        = HUE_W'(hue_v);
		h.saturation = SAT_W'(sat_v);
		h.brightness = CHAN_W'(val_v);
		return h;
	endfunction

	// Queue one corner pixel; a typed expectation is used only when fixed is set.
	task automatic add_corner(int r, int g, int b, bit fixed, int hue_v = 0,
			int sat_v = 0, int val_v = 0);
		corner_row_t row;
		row.px.red   = CHAN_W'(r);
		row.px.green = CHAN_W'(g);
		row.px.blue  = CHAN_W'(b);
		row.fixed    = fixed;
		row.want     = make_hsv(hue_v, sat_v, val_v);
		corner_rows.push_back(row);
	endtask

	// Random pixel, weighted toward greys, ties, tiny values and saturated
	// channels so the max/min selection and the wrap see plenty of traffic.
	function automatic pixel_t random_pixel();
		pixel_t p;
		int     kind, top, third, slot;
		kind    = $urandom_range(9);
		p.red   = CHAN_W'($urandom_range(255));
		p.green = CHAN_W'($urandom_range(255));
		p.blue  = CHAN_W'($urandom_range(255));
		case (kind)
			5: begin
				p.green = p.red;
				p.blue  = p.red;
			end
			6: begin
				top   = $urandom_range(255);
				third = $urandom_range(top);
				slot  = $urandom_range(2);
				p.red   = CHAN_W'((slot == 0) ? third : top);
				p.green = CHAN_W'((slot == 1) ? third : top);
				p.blue  = CHAN_W'((slot == 2) ? third : top);
			end
			7: begin
				p.red   = CHAN_W'($urandom_range(3));
				p.green = CHAN_W'($urandom_range(3));
				p.blue  = CHAN_W'($urandom_range(3));
			end
			8: begin
				p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			9: begin
				slot = $urandom_range(2);
				if (slot == 0) p.red = 8'hFF;
				else if (slot == 1) p.green = 8'hFF;
				else p.blue = 8'hFF;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Present one request at the falling edge, idling at random first, and
	// hold it until a rising edge sees busy low.
	task automatic send_pixel(pixel_t p, bit fixed, hsv_t want);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				start     <= 1'b1;
				pixel     <= p;
				row_fixed <= fixed;
				row_want  <= want;
				@(posedge clk);
				taken = !busy;
			end
		end
	endtask

	// Drop start and wait until every outstanding result has come back.
	task automatic hold_until_drained();
		int n;
		n = 0;
		@(negedge clk);
		start <= 1'b0;
		while (hsv_pending.size() > 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
				want_v, got_v);
		end
	endtask

	// Checker: retire a result against the oldest expectation, then record the
	// request taken at this edge. Inputs were driven at the falling edge, so
	// they are stable here; outputs still show their pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (hsv_pending.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result, expected none, got hue=%0d sat=%0d val=%0d",
						$time, hsv.hue, hsv.saturation, hsv.brightness);
				end else begin
					hsv_head = hsv_pending.pop_front();
					check_field("hue", hsv_head.hue, hsv.hue);
					check_field("saturation", hsv_head.saturation, hsv.saturation);
					check_field("brightness", hsv_head.brightness, hsv.brightness);
					n_results++;
				end
			end
			if (start && !busy) begin
				hsv_pending.push_back(row_fixed ? row_want : convert_pixel(pixel));
				n_requests++;
			end
		end
	end

	// Stimulus: reset once, walk the corner table, then random phases with
	// different sender idle rates, draining the pipe between phases.
	initial begin
		int idle_plan[4];
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		pixel      = '0;
		row_fixed  = 1'b0;
		row_want   = '0;
		idle_pct   = 0;
		n_requests = 0;
		n_results  = 0;
		n_errors   = 0;
		idle_plan  = '{0, 83, 0, 23};

		// Black, white and grey: no hue, no saturation.
		add_corner(0, 0, 0, 1, 0, 0, 0);
		add_corner(255, 255, 255, 1, 0, 0, 255);
		add_corner(128, 128, 128, 1, 0, 0, 128);
		add_corner(1, 1, 1, 1, 0, 0, 1);
		// Primaries and the smallest nonzero red.
		add_corner(255, 0, 0, 1, 0, 65536, 255);
		add_corner(0, 255, 0, 1, 7680, 65536, 255);
		add_corner(0, 0, 255, 1, 15360, 65536, 255);
		add_corner(1, 0, 0, 1, 0, 65536, 1);
		// Secondaries: ties for the max resolve red, then green.
		add_corner(255, 255, 0, 1, 3840, 65536, 255);
		add_corner(0, 255, 255, 1, 11520, 65536, 255);
		add_corner(255, 0, 255, 1, 19200, 65536, 255);
		// Hues next to sextant boundaries; negative red-sextant hues wrap to just under a full turn.
		add_corner(255, 0, 1, 0);
		add_corner(1, 0, 1, 0);
		add_corner(255, 1, 0, 0);
		add_corner(0, 255, 1, 0);
		add_corner(1, 255, 0, 0);
		add_corner(0, 1, 255, 0);
		add_corner(1, 0, 255, 0);
		add_corner(0, 1, 1, 0);
		// Delta of one at the top of the range.
		add_corner(255, 254, 254, 0);
		add_corner(254, 255, 255, 0);
		add_corner(255, 255, 254, 0);
		// Mid-range mixes.
		add_corner(170, 85, 0, 0);
		add_corner(85, 170, 255, 0);
		add_corner(200, 100, 150, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (corner_rows[i])
			send_pixel(corner_rows[i].px, corner_rows[i].fixed, corner_rows[i].want);
		hold_until_drained();

		foreach (idle_plan[ph]) begin
			idle_pct = idle_plan[ph];
			repeat (RANDOM_ITEMS / 4) send_pixel(random_pixel(), 1'b0, '0);
			hold_until_drained();
		end

		// Watch for stray results after the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (hsv_pending.size() > 0) begin
			n_errors += hsv_pending.size();
			$display("%0t: %0d results expected but never received", $time,
				hsv_pending.size());
		end

		$display("Converted %0d pixels (%0d corner cases, rest random), %0d results checked,",
			n_requests, corner_rows.size(), n_results);
		$display("sender idle rates 0, 83, 0 and 23 percent; %0d errors", n_errors);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
